/* hdl/assert_macros.svh */
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* hdl/gh_pkg.sv */
package gh_pkg;

  // bin counter width and histogram size
  localparam int CNT_W    = 24;
  localparam int NUM_BINS = 256;
  localparam int BIN_AW   = $clog2(NUM_BINS);

  // payload widths
  localparam int FUNC_W  = 2;
  localparam int PIX_W   = 8;
  localparam int DH_W    = 16;
  localparam int OUT_CW  = 24;
  localparam int PROD_W  = CNT_W + DH_W;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DH_W-1:0]   dh_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam cnt_t CNT_MAX  = '1;
  localparam dh_t  DH_RESET = dh_t'(400);

  // function codes
  localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

endpackage

/* hdl/gray_histogram_normalizer.sv */
// channel   | ports                                          | direction
// ----------+------------------------------------------------+----------
// in        | in_valid/in_ready, func, gray_level, bin_index | to block
// out       | out_valid/out_ready, bin_count, peak, bar      | from block
// cfg       | cfg_valid/cfg_ready, display_height            | to block
//
// accumulate: bin memory read, then increment and write back
// read: memory read, multiply, 16 divide steps, output load; the divide steps are skipped at zero peak
// clear and unused codes: taken in idle; clear drops every bin valid bit and the peak at once
// rst_n is synchronous; bins read as zero until written, no clearing pass
// a read result waits in the output register while the next transaction is taken;
// a second read stalls in its output-load state until the output register is free
`include "assert_macros.svh"

module gray_histogram_normalizer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gh_pkg::FUNC_W-1:0]  in_func,
  input  logic [gh_pkg::PIX_W-1:0]   in_gray_level,
  input  logic [gh_pkg::BIN_AW-1:0]  in_bin_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gh_pkg::OUT_CW-1:0]  out_bin_count,
  output logic [gh_pkg::OUT_CW-1:0]  out_peak_count,
  output logic [gh_pkg::DH_W-1:0]    out_bar_height,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gh_pkg::DH_W-1:0]    cfg_display_height
);
  import gh_pkg::*;

  localparam int STEP_W = $clog2(DH_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DH_W - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic                in_acc;
  logic [BIN_AW-1:0]   raddr;
  logic [BIN_AW-1:0]   addr_r;
  logic [NUM_BINS-1:0] vld_r;
  logic                rvld_r;
  cnt_t                rdata_r;
  cnt_t                mem [NUM_BINS];
  cnt_t                peak_r;
  dh_t                 display_height_r;
  cnt_t                cur_cnt;
  cnt_t                inc_cnt;
  prod_t               prod;
  cnt_t                cnt_r;
  cnt_t                rem_r;
  dh_t                 q_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                ge;
  logic                out_valid_r;
  logic [OUT_CW-1:0]   out_bin_count_r;
  logic [OUT_CW-1:0]   out_peak_count_r;
  dh_t                 out_bar_height_r;
  logic                out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign raddr     = (in_func == FUNC_READ) ? in_bin_index : BIN_AW'(in_gray_level);

  // count of the bin just read; never-written bins read as zero
  assign cur_cnt = rvld_r ? rdata_r : '0;
  assign inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign prod    = PROD_W'(cur_cnt) * PROD_W'(display_height_r);

  // one restoring divide step, next dividend bit from the top of the quotient
  assign trial = {rem_r, q_r[DH_W-1]};
  assign diff  = trial - {1'b0, peak_r};
  assign ge    = (trial >= {1'b0, peak_r});

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_func == FUNC_ACCUM) state_nxt = S_ACC;
        else if (in_acc && in_func == FUNC_READ) state_nxt = S_MUL;
      end
      S_ACC: state_nxt = S_IDLE;
      S_MUL: state_nxt = (peak_r == '0) ? S_OUT : S_DIV;
      S_DIV: if (step_r == STEP_LAST) state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      vld_r            <= '0;
      peak_r           <= '0;
      display_height_r <= DH_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) display_height_r <= cfg_display_height;
      if (in_acc && in_func == FUNC_CLEAR) begin
        vld_r  <= '0;
        peak_r <= '0;
      end
      if (state_r == S_ACC) begin
        vld_r[addr_r] <= 1'b1;
        if (inc_cnt > peak_r) peak_r <= inc_cnt;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // bin memory, one read and one write port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rdata_r <= mem[raddr];
      rvld_r  <= vld_r[raddr];
      addr_r  <= raddr;
    end
    if (state_r == S_ACC) mem[addr_r] <= inc_cnt;
  end

  // multiply, then divide by the peak one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      cnt_r  <= cur_cnt;
      rem_r  <= prod[PROD_W-1:DH_W];
      q_r    <= (peak_r == '0) ? '0 : prod[DH_W-1:0];
      step_r <= '0;
    end else if (state_r == S_DIV) begin
      rem_r  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q_r    <= {q_r[DH_W-2:0], ge};
      step_r <= step_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_count_r  <= OUT_CW'(cnt_r);
      out_peak_count_r <= OUT_CW'(peak_r);
      out_bar_height_r <= q_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_peak_count = out_peak_count_r;
  assign out_bar_height = out_bar_height_r;

  `ASSERT_SAME(a_rem_below_peak, state_r == S_DIV, rem_r < peak_r)
  `ASSERT_NEXT(a_peak_covers_bin, state_r == S_ACC, peak_r >= $past(inc_cnt))
  `ASSERT_NEXT(a_clear_empties, in_acc && in_func == FUNC_CLEAR, peak_r == '0 && vld_r == '0)
  `ASSERT_NEXT(a_div_ends, state_r == S_DIV && step_r == STEP_LAST, state_r == S_OUT)

endmodule
